>>> rtl/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
// Types and constants of the linear probing hash table.
// No dependencies; imported by lpht_hash, lpht_cfg and the top level.
package lpht_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int MAXI_W   = 11;
    localparam int MARK_W   = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [MARK_W-1:0]   t_mark;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;
    localparam t_kind KIND_LOOKUP = 2'd2;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_HIT      = 2'd1;
    localparam t_status ST_MISS     = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    localparam t_mark MARK_EMPTY   = 2'd0;
    localparam t_mark MARK_USED    = 2'd1;
    localparam t_mark MARK_DELETED = 2'd2;

    typedef struct packed {
        t_mark               mark;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   payload;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // APB register file: one register, word index in paddr[2]
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITEMS = 1'b0;
    localparam logic [MAXI_W-1:0]    MAX_ITEMS_RST = 11'd1024;

endpackage

>>> rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot store of the hash table.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lpht_hash.sv
// Home slot unit: key mod SLOTS.
// Uses lpht_pkg. A mask for power-of-two SLOTS, else a reciprocal multiply.
module lpht_hash #(
    parameter int SLOTS = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [lpht_pkg::KEY_W-1:0]              i_key,
    output logic                                    o_done,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_home
);

    import lpht_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    generate
        if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
            logic          r_done;
            logic [AW-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_home <= i_key[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_divide
            // quotient = (key * RECIP) >> SHIFT, exact for every 31-bit key
            localparam int SHIFT  = KEY_W + AW;
            localparam int PROD_W = KEY_W + 16;
            localparam logic [63:0] RECIP =
                ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
            localparam logic [15:0]      M_LO    = RECIP[15:0];
            localparam logic [15:0]      M_HI    = RECIP[31:16];
            localparam logic [KEY_W-1:0] MODULUS = KEY_W'(SLOTS);

            logic              r_v1;
            logic              r_v2;
            logic              r_done;
            logic [AW-1:0]     r_key_lo;
            logic [PROD_W-1:0] r_prod_lo;
            logic [PROD_W-1:0] r_prod_hi;
            logic [KEY_W-1:0]  r_quot;
            logic [AW-1:0]     r_home;
            logic [63:0]       prod_sum;
            logic [KEY_W-1:0]  quot_mul;

            assign prod_sum = {1'b0, r_prod_hi, 16'b0} + 64'(r_prod_lo);
            assign quot_mul = r_quot * MODULUS;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_start;
                    r_v2   <= r_v1;
                    r_done <= r_v2;
                end
                if (i_start) begin
                    r_key_lo  <= i_key[AW-1:0];
                    r_prod_lo <= PROD_W'(i_key) * PROD_W'(M_LO);
                    r_prod_hi <= PROD_W'(i_key) * PROD_W'(M_HI);
                end
                if (r_v1) begin
                    r_quot <= KEY_W'(prod_sum >> SHIFT);
                end
                if (r_v2) begin
                    r_home <= r_key_lo - quot_mul[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end
    endgenerate

endmodule

>>> rtl/lpht_cfg.sv
// APB register file holding max_items.
// Uses lpht_pkg for register index and reset value.
module lpht_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpht_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lpht_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lpht_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [lpht_pkg::MAXI_W-1:0]         o_max_items
);

    import lpht_pkg::*;

    logic [MAXI_W-1:0]    r_max_items;
    logic [MAXI_W-1:0]    n_max_items;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_max_items = r_max_items;
        if (wr_en && (reg_idx == REG_MAX_ITEMS)) begin
            n_max_items = pwdata[MAXI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_items <= MAX_ITEMS_RST;
        end else begin
            r_max_items <= n_max_items;
        end
    end

    assign prdata      = (reg_idx == REG_MAX_ITEMS) ? CFG_DATA_W'(r_max_items) : '0;
    assign pready      = 1'b1;
    assign o_max_items = r_max_items;

endmodule

>>> rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing and deleted-slot marks. After reset the
// block runs a clearing pass over every slot of the slot store and stalls requests until
// it ends. A request is then taken in S_IDLE; an insert at the limit or an unknown kind
// goes straight to S_FINISH, any other has its home slot computed in S_HASH (a mask when
// SLOTS is a power of two, reciprocal multiplication otherwise) and its slots read and
// checked in S_PROBE. S_FINISH loads the result register once that is empty or its result
// is taken. Probes run one slot per cycle through the single read port of the slot RAM.
// The result register lets the next request enter while a result waits.
// Depends on lpht_pkg, lpht_ram, lpht_hash, lpht_cfg and assert_macros.svh.
`include "assert_macros.svh"

module linear_probe_hash_table #(
    parameter int SLOTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lpht_pkg::t_kind                     i_kind,
    input  logic [lpht_pkg::KEY_W-1:0]          i_key,
    input  logic [lpht_pkg::DATA_W-1:0]         i_payload,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lpht_pkg::t_status                   o_status,
    output logic [lpht_pkg::DATA_W-1:0]         o_found_payload,
    output logic [lpht_pkg::TOTAL_W-1:0]        o_item_total,
    output logic                                o_is_full,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpht_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lpht_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lpht_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import lpht_pkg::*;

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int EXT_W = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]        r_state,     n_state;
    logic [AW-1:0]     r_clr_addr,  n_clr_addr;
    logic [CW-1:0]     r_count,     n_count;
    logic [AW-1:0]     r_pos,       n_pos;
    logic [AW-1:0]     r_chk_pos;
    logic              r_chk_valid, n_chk_valid;
    logic [AW-1:0]     r_probes,    n_probes;
    t_status           r_status,    n_status;
    logic [DATA_W-1:0] r_found,     n_found;
    t_kind             r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_payload;

    logic              r_o_valid,   n_o_valid;
    t_status           r_o_status;
    logic [DATA_W-1:0] r_o_found;
    logic [TOTAL_W-1:0] r_o_total;
    logic              r_o_full;

    logic [MAXI_W-1:0] max_items;
    logic [EXT_W-1:0]  count_ext;
    logic [EXT_W-1:0]  max_ext;
    logic              at_limit;
    logic              accept;
    logic              hash_start;
    logic              hash_done;
    logic [AW-1:0]     hash_home;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wentry;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_entry;

    lpht_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_items (max_items)
    );

    lpht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign count_ext = EXT_W'(r_count);
    assign max_ext   = EXT_W'(max_items);
    assign at_limit  = (count_ext >= max_ext);

    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && !o_stall;
    assign hash_start = accept &&
                        ((i_kind == KIND_INSERT && !at_limit) ||
                         i_kind == KIND_DELETE || i_kind == KIND_LOOKUP);
    assign ram_raddr  = r_pos;
    assign out_load   = (r_state == S_FINISH) && (!r_o_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_pos       = r_pos;
        n_chk_valid = 1'b0;
        n_probes    = r_probes;
        n_status    = r_status;
        n_found     = r_found;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_pos;
        ram_wentry  = rd_entry;

        unique case (r_state)
            S_CLEAR: begin
                ram_we             = 1'b1;
                ram_waddr          = r_clr_addr;
                ram_wentry.mark    = MARK_EMPTY;
                ram_wentry.key     = '0;
                ram_wentry.payload = '0;
                n_clr_addr         = (r_clr_addr == LAST) ? '0 : r_clr_addr + 1'b1;
                if (r_clr_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_found = '0;
                    if (hash_start) begin
                        n_state = S_HASH;
                    end else begin
                        n_status = (i_kind == KIND_INSERT) ? ST_FULL : ST_MISS;
                        n_state  = S_FINISH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_pos    = hash_home;
                    n_probes = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                n_pos       = (r_pos == LAST) ? '0 : r_pos + 1'b1;
                n_chk_valid = 1'b1;
                if (r_chk_valid) begin
                    n_probes = r_probes + 1'b1;
                    if (r_kind == KIND_INSERT) begin
                        if (rd_entry.mark != MARK_USED) begin
                            ram_we             = 1'b1;
                            ram_wentry.mark    = MARK_USED;
                            ram_wentry.key     = r_key;
                            ram_wentry.payload = r_payload;
                            n_count            = r_count + 1'b1;
                            n_status           = ST_INSERTED;
                            n_chk_valid        = 1'b0;
                            n_state            = S_FINISH;
                        end else if (r_probes == LAST) begin
                            n_status    = ST_FULL;
                            n_chk_valid = 1'b0;
                            n_state     = S_FINISH;
                        end
                    end else begin
                        if (rd_entry.mark == MARK_EMPTY) begin
                            n_status    = ST_MISS;
                            n_chk_valid = 1'b0;
                            n_state     = S_FINISH;
                        end else if (rd_entry.mark == MARK_USED && rd_entry.key == r_key) begin
                            n_status    = ST_HIT;
                            n_chk_valid = 1'b0;
                            n_state     = S_FINISH;
                            if (r_kind == KIND_DELETE) begin
                                ram_we          = 1'b1;
                                ram_wentry.mark = MARK_DELETED;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                n_found = rd_entry.payload;
                            end
                        end else if (r_probes == LAST) begin
                            n_status    = ST_MISS;
                            n_chk_valid = 1'b0;
                            n_state     = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_o_valid = (r_o_valid && i_stall) || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_chk_valid <= n_chk_valid;
            r_o_valid   <= n_o_valid;
        end
        r_pos     <= n_pos;
        r_chk_pos <= r_pos;
        r_probes  <= n_probes;
        r_status  <= n_status;
        r_found   <= n_found;
        if (accept) begin
            r_kind    <= i_kind;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
        if (out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_total  <= count_ext[TOTAL_W-1:0];
            r_o_full   <= at_limit;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found_payload = r_o_found;
    assign o_item_total    = r_o_total;
    assign o_is_full       = r_o_full;

    `ASSERT_IMPLIES(a_clear_stalls, i_clk, i_rst_n, r_state == S_CLEAR, o_stall,
                    "request taken during clearing pass")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(SLOTS),
                   "item count above slot count")
    `ASSERT_IMPLIES(a_write_src, i_clk, i_rst_n, ram_we,
                    (r_state == S_CLEAR) || (r_state == S_PROBE && r_chk_valid),
                    "slot write outside clear or probe check")
    `ASSERT_NEXT(a_finish_holds, i_clk, i_rst_n, r_state == S_FINISH && r_o_valid && i_stall,
                 r_state == S_FINISH, "result overwrote a waiting result")
    `ASSERT_NEXT(a_count_probe_only, i_clk, i_rst_n, r_state != S_PROBE, $stable(r_count),
                 "item count changed outside probing")

endmodule

>>> verif/linear_probe_hash_table_test.sv
// Testbench for linear_probe_hash_table: directed and random insert, delete and lookup
// requests, checked against a slot-level model of the probing table kept in the bench.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int SLOTS = 1024;
    localparam t_kind KIND_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_ITEMS = {REG_MAX_ITEMS, 2'b00};

    typedef struct {
        t_kind               kind;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   payload;
    } t_request;

    typedef struct {
        t_status             status;
        logic [DATA_W-1:0]   found;
        logic [TOTAL_W-1:0]  total;
        logic                full;
    } t_answer;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    t_kind                   i_kind = KIND_INSERT;
    logic [KEY_W-1:0]        i_key = '0;
    logic [DATA_W-1:0]       i_payload = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_status                 o_status;
    logic [DATA_W-1:0]       o_found_payload;
    logic [TOTAL_W-1:0]      o_item_total;
    logic                    o_is_full;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // table model
    t_mark                   slot_state [SLOTS];
    logic [KEY_W-1:0]        slot_keys [SLOTS];
    logic [DATA_W-1:0]       slot_data [SLOTS];
    int unsigned             held_items;
    int unsigned             max_items_now;

    t_request                requests_to_send [$];
    t_answer                 answers_due [$];
    int                      queued_total = 0;
    int                      accepted_total = 0;
    int                      fail_count = 0;
    logic                    req_taken = 1'b0;
    logic                    res_taken = 1'b0;
    int                      gap_left = 0;
    int                      hold_left = 0;
    bit                      calm = 1'b0;

    linear_probe_hash_table #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_key(i_key),
        .i_payload(i_payload),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_found_payload(o_found_payload),
        .o_item_total(o_item_total),
        .o_is_full(o_is_full),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag(string msg);
        $display("error at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic int find_used(logic [KEY_W-1:0] key);
        int unsigned pos;
        int n;
        pos = key % SLOTS;
        for (n = 0; n < SLOTS; n++) begin
            if (slot_state[pos] == MARK_EMPTY) return -1;
            if (slot_state[pos] == MARK_USED && slot_keys[pos] == key) return int'(pos);
            pos = (pos + 1) % SLOTS;
        end
        return -1;
    endfunction

    function automatic t_answer table_apply(t_request rq);
        t_answer ans;
        int unsigned pos;
        int n;
        int hit;
        ans.status = ST_MISS;
        ans.found = '0;
        if (rq.kind == KIND_INSERT) begin
            ans.status = ST_FULL;
            if (held_items < max_items_now) begin
                pos = rq.key % SLOTS;
                for (n = 0; n < SLOTS; n++) begin
                    if (slot_state[pos] != MARK_USED) begin
                        slot_state[pos] = MARK_USED;
                        slot_keys[pos] = rq.key;
                        slot_data[pos] = rq.payload;
                        held_items++;
                        ans.status = ST_INSERTED;
                        break;
                    end
                    pos = (pos + 1) % SLOTS;
                end
            end
        end else if (rq.kind == KIND_DELETE) begin
            hit = find_used(rq.key);
            if (hit >= 0) begin
                slot_state[hit] = MARK_DELETED;
                if (held_items > 0) held_items--;
                ans.status = ST_HIT;
            end
        end else if (rq.kind == KIND_LOOKUP) begin
            hit = find_used(rq.key);
            if (hit >= 0) begin
                ans.found = slot_data[hit];
                ans.status = ST_HIT;
            end
        end
        ans.total = TOTAL_W'(held_items);
        ans.full = (held_items >= max_items_now);
        return ans;
    endfunction

    // request and result handshakes, prediction and checking
    always @(posedge i_clk) begin : watch_ports
        t_request rq;
        t_answer want;
        req_taken <= i_rst_n && i_valid && !o_stall;
        res_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                flag("result with no request outstanding");
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status)
                    flag($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_found_payload !== want.found)
                    flag($sformatf("found_payload %h, expected %h",
                                   o_found_payload, want.found));
                if (o_item_total !== want.total)
                    flag($sformatf("item_total %0d, expected %0d", o_item_total, want.total));
                if (o_is_full !== want.full)
                    flag($sformatf("is_full %b, expected %b", o_is_full, want.full));
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            rq.kind = i_kind;
            rq.key = i_key;
            rq.payload = i_payload;
            answers_due.push_back(table_apply(rq));
            accepted_total <= accepted_total + 1;
        end
    end

    always @(negedge i_clk) begin : drive_requests
        t_request rq;
        if (i_rst_n) begin
            if (req_taken) gap_left = calm ? 0 : $urandom_range(0, 7);
            if (i_valid && !req_taken) begin
                // held until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (requests_to_send.size() > 0) begin
                rq = requests_to_send.pop_front();
                i_kind <= rq.kind;
                i_key <= rq.key;
                i_payload <= rq.payload;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_stall
        if (res_taken) hold_left = calm ? 0 : $urandom_range(0, 7);
        i_stall <= (hold_left > 0);
        if (hold_left > 0 && o_valid) hold_left--;
    end

    task automatic queue_request(t_kind kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] pl);
        t_request rq;
        rq.kind = kind;
        rq.key = key;
        rq.payload = pl;
        requests_to_send.push_back(rq);
        queued_total++;
    endtask

    task automatic drain();
        while (!(accepted_total == queued_total && answers_due.size() == 0))
            @(negedge i_clk);
    endtask

    task automatic set_max_items(int unsigned value);
        drain();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_ITEMS;
        pwdata <= CFG_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        max_items_now = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // keys cluster on a dozen home slots so that probe chains, tombstones and hits are common
    task automatic random_burst(int count);
        int unsigned hot;
        int unsigned pick;
        logic [KEY_W-1:0] key;
        t_kind kind;
        hot = $urandom_range(0, SLOTS - 1);
        calm = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = pick < 42 ? KIND_INSERT : pick < 66 ? KIND_DELETE :
                   pick < 95 ? KIND_LOOKUP : KIND_SPARE;
            if ($urandom_range(0, 9) == 0)
                key = KEY_W'($urandom);
            else
                key = KEY_W'($urandom_range(0, 3) * SLOTS +
                             (hot + $urandom_range(0, 11)) % SLOTS);
            queue_request(kind, key, $urandom);
        end
    endtask

    initial begin : stimulus
        int phase_limits [7];
        for (int n = 0; n < SLOTS; n++) begin
            slot_state[n] = MARK_EMPTY;
            slot_keys[n] = '0;
            slot_data[n] = '0;
        end
        held_items = 0;
        max_items_now = MAX_ITEMS_RST;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, wrap-around probing, tombstones, duplicates, spare kind
        queue_request(KIND_LOOKUP, 31'd5, 32'h0);
        queue_request(KIND_DELETE, 31'd5, 32'h0);
        queue_request(KIND_SPARE, 31'd7, 32'h1234_5678);
        queue_request(KIND_INSERT, 31'd0, 32'h0);
        queue_request(KIND_INSERT, 31'd1024, 32'hffff_ffff);
        queue_request(KIND_INSERT, 31'h7fff_ffff, 32'ha5a5_a5a5);
        queue_request(KIND_INSERT, 31'd1023, 32'h0bad_cafe);
        queue_request(KIND_LOOKUP, 31'd1023, 32'h0);
        queue_request(KIND_LOOKUP, 31'h7fff_ffff, 32'h0);
        queue_request(KIND_LOOKUP, 31'd2048, 32'h0);
        queue_request(KIND_DELETE, 31'd0, 32'h0);
        queue_request(KIND_LOOKUP, 31'd1024, 32'h0);
        queue_request(KIND_LOOKUP, 31'd0, 32'h0);
        queue_request(KIND_DELETE, 31'd0, 32'h0);
        queue_request(KIND_INSERT, 31'd1024, 32'h0000_0001);
        queue_request(KIND_LOOKUP, 31'd1024, 32'h0);
        queue_request(KIND_DELETE, 31'd1024, 32'h0);
        queue_request(KIND_DELETE, 31'd1024, 32'h0);
        queue_request(KIND_LOOKUP, 31'd1024, 32'h0);
        queue_request(KIND_SPARE, 31'd0, 32'hffff_ffff);
        queue_request(KIND_INSERT, 31'h5555_5555, 32'h5555_5555);
        queue_request(KIND_INSERT, 31'h2aaa_aaaa, 32'haaaa_aaaa);
        queue_request(KIND_LOOKUP, 31'h2aaa_aaaa, 32'h0);

        set_max_items(0);
        random_burst(12);

        phase_limits = '{2047, 3, 40, 5, 1, 1024, 0};
        phase_limits[6] = $urandom_range(6, 100);
        foreach (phase_limits[p]) begin
            set_max_items(phase_limits[p]);
            random_burst(100);
        end

        // wrap-around keys after the limit is raised again
        set_max_items(1024);
        calm = 1'b0;
        queue_request(KIND_INSERT, 31'h7fff_ffff, $urandom);
        queue_request(KIND_INSERT, 31'd77, $urandom);
        queue_request(KIND_LOOKUP, 31'd77, 32'h0);
        queue_request(KIND_INSERT, 31'd0, $urandom);
        queue_request(KIND_LOOKUP, 31'h7fff_ffff, 32'h0);

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #40000000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_hash.sv
rtl/lpht_cfg.sv
rtl/linear_probe_hash_table.sv
verif/linear_probe_hash_table_test.sv
